FILE: src/linear_interp_pcm_resampler_top_assert.svh
// Assertion macros for the resampler checker.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef LINEAR_INTERP_PCM_RESAMPLER_TOP_ASSERT_SVH
`define LINEAR_INTERP_PCM_RESAMPLER_TOP_ASSERT_SVH

// Condition that must hold at every clock edge outside reset
`define LIPR_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent in one cycle implies consequent in the next
`define LIPR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/lipr_pkg.sv
`default_nettype none

package lipr_pkg;

    // Field widths
    localparam int SAMPLE_W    = 16;
    localparam int RATE_W      = 17;
    localparam int CFG_INDEX_W = 2;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_INPUT_RATE  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_OUTPUT_RATE = 2'd1;

    // Rate register reset value
    localparam logic [RATE_W-1:0] RATE_RESET = 17'd48000;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [RATE_W-1:0]          rate_t;

endpackage

`default_nettype wire

FILE: src/linear_interp_pcm_resampler_top.sv
// Pass-through (equal rates): each input frame is registered and sent out unchanged from S_PASS;
// a new frame is taken only after the last one is done. Interpolating: each result passes check,
// left/right multiply on one shared unit, and emit, each run ends in a further check, and output
// stall holds emit. A config write stalls input until the phase step is ready, while
// a restoring divider computes it one quotient bit per cycle (skipped when the step saturates).
// Reset (rst_n, async low): idle, no previous frame, phase 0, both rates 48000, step one.
`default_nettype none

module linear_interp_pcm_resampler_top
    import lipr_pkg::*;
#(
    parameter int PHASE_FRAC_BITS = 16,
    parameter int MAX_RUN         = 16
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // configuration write port
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [RATE_W-1:0]      cfg_data,
    // input channel
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic signed [SAMPLE_W-1:0] left_in,
    input  wire logic signed [SAMPLE_W-1:0] right_in,
    input  wire logic                   block_end,
    // output channel
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic signed [SAMPLE_W-1:0]  left_out,
    output logic signed [SAMPLE_W-1:0]  right_out,
    output logic                        run_last
);

    localparam int F   = PHASE_FRAC_BITS;
    localparam int PW  = F + 5;               // phase width
    localparam int SW  = F + 4;               // step width
    localparam int CW  = $clog2(MAX_RUN + 1); // run counter width
    localparam int AW  = F + SAMPLE_W + 2;    // accumulator width
    localparam int DCW = $clog2(SW);          // divider counter width

    localparam logic [PW-1:0] ONE_PH   = PW'(1) << F;
    localparam logic [PW-1:0] TWO_PH   = PW'(1) << (F + 1);
    localparam logic [SW-1:0] STEP_ONE = SW'(1) << F;
    localparam logic [SW-1:0] STEP_MAX = {SW{1'b1}};
    localparam logic [CW-1:0] MAX_CNT  = CW'(MAX_RUN);
    localparam logic [DCW-1:0] DIV_LAST = DCW'(SW - 1);

    // sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_PASS   = 3'd1;
    localparam logic [2:0] S_CHECK  = 3'd2;
    localparam logic [2:0] S_MUL_L  = 3'd3;
    localparam logic [2:0] S_MUL_R  = 3'd4;
    localparam logic [2:0] S_EMIT   = 3'd5;
    localparam logic [2:0] S_DSTART = 3'd6;
    localparam logic [2:0] S_DIV    = 3'd7;

    // control state
    logic [2:0]     state_reg, state_next;
    rate_t          in_rate_reg, in_rate_next;
    rate_t          out_rate_reg, out_rate_next;
    logic [SW-1:0]  step_reg, step_next;
    logic           eq_reg, eq_next;
    logic [DCW-1:0] dcnt_reg, dcnt_next;
    logic [PW-1:0]  phase_reg, phase_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic           seg_reg, seg_next;
    logic           last_reg, last_next;
    logic           have_prev_reg, have_prev_next;
    logic           out_valid_reg, out_valid_next;

    // datapath
    rate_t          rem_reg, rem_next;
    logic [SW-1:0]  dsh_reg, dsh_next;
    sample_t        prev_l_reg, prev_l_next;
    sample_t        prev_r_reg, prev_r_next;
    sample_t        x_l_reg, x_l_next;
    sample_t        x_r_reg, x_r_next;
    logic signed [AW-1:0] acc_l_reg, acc_l_next;
    logic signed [AW-1:0] acc_r_reg, acc_r_next;
    sample_t        left_out_reg, left_out_next;
    sample_t        right_out_reg, right_out_next;
    logic           run_last_reg, run_last_next;

    // shared multiply-add unit
    sample_t              a_l, a_r, mul_a, mul_b;
    logic signed [SAMPLE_W:0] diff;
    logic signed [F:0]    tz;
    logic signed [AW-1:0] mac;

    // truncation toward zero
    logic signed [AW-1:0] q_l, q_r;
    sample_t              res_l, res_r;

    // run lookahead
    logic [PW-1:0] ph_n, ph_c;
    logic [CW-1:0] n1;
    logic          more;

    // divider step
    logic [RATE_W:0] rem2, rem_sub;
    logic            ge;
    logic            sat;

    logic in_take;
    logic out_free;

    assign in_stall  = (state_reg != S_IDLE) || cfg_we;
    assign in_take   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign left_out  = left_out_reg;
    assign right_out = right_out_reg;
    assign run_last  = run_last_reg;

    // operand selection: first run goes prev->x, block tail goes x->x
    assign a_l   = seg_reg ? x_l_reg : prev_l_reg;
    assign a_r   = seg_reg ? x_r_reg : prev_r_reg;
    assign mul_a = (state_reg == S_MUL_R) ? a_r : a_l;
    assign mul_b = (state_reg == S_MUL_R) ? x_r_reg : x_l_reg;
    assign diff  = $signed({mul_b[SAMPLE_W-1], mul_b}) - $signed({mul_a[SAMPLE_W-1], mul_a});
    assign tz    = $signed({1'b0, phase_reg[F-1:0]});
    // a*ONE + (b-a)*t == a*(ONE-t) + b*t
    assign mac   = (AW'(mul_a) <<< F) + (AW'(diff) * AW'(tz));

    // divide by ONE, rounding toward zero
    assign q_l   = acc_l_reg >>> F;
    assign q_r   = acc_r_reg >>> F;
    assign res_l = q_l[SAMPLE_W-1:0]
                   + SAMPLE_W'(acc_l_reg[AW-1] && (|acc_l_reg[F-1:0]));
    assign res_r = q_r[SAMPLE_W-1:0]
                   + SAMPLE_W'(acc_r_reg[AW-1] && (|acc_r_reg[F-1:0]));

    // does another result follow this one within the same input?
    assign ph_n = phase_reg + PW'(step_reg);
    assign n1   = cnt_reg + CW'(1);
    assign more = ((ph_n < ONE_PH) && (n1 < MAX_CNT))
                  || (!seg_reg && last_reg && (n1 < MAX_CNT) && (ph_n < TWO_PH));
    assign ph_c = (phase_reg < ONE_PH) ? ONE_PH : phase_reg;

    // restoring divider: one quotient bit per cycle, quotient shifts into dsh
    assign rem2    = {rem_reg, dsh_reg[SW-1]};
    assign ge      = rem2 >= {1'b0, out_rate_reg};
    assign rem_sub = rem2 - {1'b0, out_rate_reg};
    assign sat     = (out_rate_reg == '0)
                     || ({4'b0000, in_rate_reg} >= {out_rate_reg, 4'b0000});

    // next-state logic
    always_comb
    begin
        state_next     = state_reg;
        in_rate_next   = in_rate_reg;
        out_rate_next  = out_rate_reg;
        step_next      = step_reg;
        eq_next        = eq_reg;
        dcnt_next      = dcnt_reg;
        phase_next     = phase_reg;
        cnt_next       = cnt_reg;
        seg_next       = seg_reg;
        last_next      = last_reg;
        have_prev_next = have_prev_reg;
        out_valid_next = out_valid_reg;
        rem_next       = rem_reg;
        dsh_next       = dsh_reg;
        prev_l_next    = prev_l_reg;
        prev_r_next    = prev_r_reg;
        x_l_next       = x_l_reg;
        x_r_next       = x_r_reg;
        acc_l_next     = acc_l_reg;
        acc_r_next     = acc_r_reg;
        left_out_next  = left_out_reg;
        right_out_next = right_out_reg;
        run_last_next  = run_last_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    x_l_next  = left_in;
                    x_r_next  = right_in;
                    last_next = block_end;
                    cnt_next  = '0;
                    if (eq_reg)
                    begin
                        state_next = S_PASS;
                    end
                    else if (have_prev_reg)
                    begin
                        seg_next   = 1'b0;
                        state_next = S_CHECK;
                    end
                    else
                    begin
                        // first frame of a block becomes the previous frame; a one-frame block also runs its tail
                        prev_l_next    = left_in;
                        prev_r_next    = right_in;
                        have_prev_next = 1'b1;
                        if (block_end)
                        begin
                            seg_next   = 1'b1;
                            state_next = S_CHECK;
                        end
                    end
                end
            end

            S_PASS:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    left_out_next  = x_l_reg;
                    right_out_next = x_r_reg;
                    run_last_next  = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            S_CHECK:
            begin
                if ((phase_reg < ONE_PH) && (cnt_reg < MAX_CNT))
                begin
                    state_next = S_MUL_L;
                end
                else if (!seg_reg)
                begin
                    // end of prev->x run
                    phase_next     = ph_c - ONE_PH;
                    prev_l_next    = x_l_reg;
                    prev_r_next    = x_r_reg;
                    have_prev_next = 1'b1;
                    if (last_reg)
                    begin
                        seg_next = 1'b1;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    // end of block tail
                    phase_next     = '0;
                    have_prev_next = 1'b0;
                    state_next     = S_IDLE;
                end
            end

            S_MUL_L:
            begin
                acc_l_next = mac;
                state_next = S_MUL_R;
            end

            S_MUL_R:
            begin
                acc_r_next = mac;
                state_next = S_EMIT;
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    left_out_next  = res_l;
                    right_out_next = res_r;
                    run_last_next  = !more;
                    phase_next     = ph_n;
                    cnt_next       = n1;
                    state_next     = S_CHECK;
                end
            end

            S_DSTART:
            begin
                eq_next = (in_rate_reg == out_rate_reg);
                if (sat)
                begin
                    step_next  = STEP_MAX;
                    state_next = S_IDLE;
                end
                else
                begin
                    // quotient fits SW bits, so the top dividend bits sit below the divisor
                    rem_next   = {4'b0000, in_rate_reg[RATE_W-1:4]};
                    dsh_next   = {in_rate_reg[3:0], {F{1'b0}}};
                    dcnt_next  = DIV_LAST;
                    state_next = S_DIV;
                end
            end

            S_DIV:
            begin
                rem_next = ge ? rem_sub[RATE_W-1:0] : rem2[RATE_W-1:0];
                dsh_next = {dsh_reg[SW-2:0], ge};
                if (dcnt_reg == '0)
                begin
                    step_next  = {dsh_reg[SW-2:0], ge};
                    state_next = S_IDLE;
                end
                else
                begin
                    dcnt_next = dcnt_reg - DCW'(1);
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // register write restarts the step computation
        if (cfg_we)
        begin
            if (cfg_index == REG_INPUT_RATE)
            begin
                in_rate_next = cfg_data;
            end
            else if (cfg_index == REG_OUTPUT_RATE)
            begin
                out_rate_next = cfg_data;
            end
            state_next = S_DSTART;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            in_rate_reg   <= RATE_RESET;
            out_rate_reg  <= RATE_RESET;
            step_reg      <= STEP_ONE;
            eq_reg        <= 1'b1;
            dcnt_reg      <= '0;
            phase_reg     <= '0;
            cnt_reg       <= '0;
            seg_reg       <= 1'b0;
            last_reg      <= 1'b0;
            have_prev_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_rate_reg   <= in_rate_next;
            out_rate_reg  <= out_rate_next;
            step_reg      <= step_next;
            eq_reg        <= eq_next;
            dcnt_reg      <= dcnt_next;
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            seg_reg       <= seg_next;
            last_reg      <= last_next;
            have_prev_reg <= have_prev_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        rem_reg       <= rem_next;
        dsh_reg       <= dsh_next;
        prev_l_reg    <= prev_l_next;
        prev_r_reg    <= prev_r_next;
        x_l_reg       <= x_l_next;
        x_r_reg       <= x_r_next;
        acc_l_reg     <= acc_l_next;
        acc_r_reg     <= acc_r_next;
        left_out_reg  <= left_out_next;
        right_out_reg <= right_out_next;
        run_last_reg  <= run_last_next;
    end

endmodule

`default_nettype wire

FILE: src/lipr_checker.sv
`default_nettype none
`include "linear_interp_pcm_resampler_top_assert.svh"

module lipr_assert_checker
    import lipr_pkg::*;
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   cfg_we,
    input wire logic                   in_stall,
    input wire logic                   out_valid,
    input wire logic                   out_stall,
    input wire logic [SAMPLE_W-1:0]    left_out,
    input wire logic [SAMPLE_W-1:0]    right_out,
    input wire logic                   run_last
);

    // stalled result transaction holds
    `LIPR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(left_out) && $stable(right_out) && $stable(run_last), "stalled result changed")

    // a register write keeps input stalled while the step is recomputed
    `LIPR_ASSERT_NEXT(a_cfg_busy, cfg_we, in_stall, "input ready right after config write")

    // new results only come out of a busy sequencer
    `LIPR_ASSERT_ALWAYS(a_out_src, !$rose(out_valid) || $past(in_stall), "result appeared while idle")

endmodule

bind linear_interp_pcm_resampler_top lipr_assert_checker u_lipr_checker (.*);

`default_nettype wire

FILE: test/lipr_checker.sv
`timescale 1ns / 1ps

// Watches the config port and both channels, keeps its own copy of the
// resampler state, and compares every output transaction with the oldest
// predicted frame.
module lipr_checker
    import lipr_pkg::*;
#(
    parameter int PHASE_FRAC_BITS = 16,
    parameter int MAX_RUN         = 16
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [RATE_W-1:0]          cfg_data,
    input  wire logic                       in_valid,
    input  wire logic                       in_stall,
    input  wire logic signed [SAMPLE_W-1:0] left_in,
    input  wire logic signed [SAMPLE_W-1:0] right_in,
    input  wire logic                       block_end,
    input  wire logic                       out_valid,
    input  wire logic                       out_stall,
    input  wire logic signed [SAMPLE_W-1:0] left_out,
    input  wire logic signed [SAMPLE_W-1:0] right_out,
    input  wire logic                       run_last,
    output int                              mismatch_count,
    output int                              frames_due
);

    localparam longint ONE_Q    = longint'(1) << PHASE_FRAC_BITS;
    localparam longint STEP_MAX = (longint'(1) << (PHASE_FRAC_BITS + 4)) - 1;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
        logic                       last;
    } frame_t;

    // predicted frames, oldest first
    frame_t expected_frames[$];

    rate_t  in_rate;
    rate_t  out_rate;
    longint prev_l;
    longint prev_r;
    logic   have_prev;
    longint phase_acc;
    longint phase_inc;
    int     run_len;
    int     errs;

    // Q16 step, saturated; zero output rate gives the maximum
    function automatic longint step_for(rate_t ir, rate_t orate);
        longint s;
        if (orate == '0)
            return STEP_MAX;
        s = (longint'(ir) << PHASE_FRAC_BITS) / longint'(orate);
        return (s > STEP_MAX) ? STEP_MAX : s;
    endfunction

    // weighted mix of two samples, division truncates toward zero
    function automatic logic signed [SAMPLE_W-1:0] blend(longint a, longint b, longint t);
        longint acc;
        acc = a * (ONE_Q - t) + b * t;
        return SAMPLE_W'(acc / ONE_Q);
    endfunction

    // frames between a and b at each phase below one, capped per input
    task automatic emit_run(input longint al, input longint ar,
                            input longint bl, input longint br);
        frame_t f;
        while (phase_acc < ONE_Q && run_len < MAX_RUN) begin
            f.left  = blend(al, bl, phase_acc);
            f.right = blend(ar, br, phase_acc);
            f.last  = 1'b0;
            expected_frames.push_back(f);
            run_len++;
            phase_acc = phase_acc + phase_inc;
        end
        // cap hit: skip the rest of the positions below one
        if (phase_acc < ONE_Q)
            phase_acc = ONE_Q;
    endtask

    always @(posedge clk or negedge rst_n) begin : track
        frame_t want;
        if (!rst_n) begin
            in_rate   = RATE_RESET;
            out_rate  = RATE_RESET;
            phase_inc = step_for(RATE_RESET, RATE_RESET);
            phase_acc = 0;
            prev_l    = 0;
            prev_r    = 0;
            have_prev = 1'b0;
            run_len   = 0;
            errs      = 0;
            expected_frames.delete();
            mismatch_count <= 0;
            frames_due     <= 0;
        end
        else begin
            // output transaction against the oldest prediction
            if (out_valid && !out_stall) begin
                if (expected_frames.size() == 0) begin
                    $display("%0t: unexpected result left_out=%0d right_out=%0d run_last=%0b",
                             $time, left_out, right_out, run_last);
                    errs++;
                end
                else begin
                    want = expected_frames.pop_front();
                    if (left_out !== want.left) begin
                        $display("%0t: left_out expected %0d, actual %0d",
                                 $time, want.left, left_out);
                        errs++;
                    end
                    if (right_out !== want.right) begin
                        $display("%0t: right_out expected %0d, actual %0d",
                                 $time, want.right, right_out);
                        errs++;
                    end
                    if (run_last !== want.last) begin
                        $display("%0t: run_last expected %0b, actual %0b",
                                 $time, want.last, run_last);
                        errs++;
                    end
                end
            end

            // input transaction: predict its frames
            if (in_valid && !in_stall) begin
                if (in_rate == out_rate) begin
                    // equal rates: straight through, state untouched
                    want.left  = left_in;
                    want.right = right_in;
                    want.last  = 1'b1;
                    expected_frames.push_back(want);
                end
                else begin
                    run_len = 0;
                    if (have_prev) begin
                        emit_run(prev_l, prev_r, left_in, right_in);
                        phase_acc = phase_acc - ONE_Q;
                    end
                    prev_l    = left_in;
                    prev_r    = right_in;
                    have_prev = 1'b1;
                    // block end: hold the frame out, then start afresh
                    if (block_end) begin
                        emit_run(prev_l, prev_r, prev_l, prev_r);
                        phase_acc = 0;
                        have_prev = 1'b0;
                        prev_l    = 0;
                        prev_r    = 0;
                    end
                    if (run_len > 0) begin
                        want = expected_frames.pop_back();
                        want.last = 1'b1;
                        expected_frames.push_back(want);
                    end
                end
            end

            // register write; unknown indexes leave everything as it was
            if (cfg_we) begin
                if (cfg_index == REG_INPUT_RATE)
                    in_rate = cfg_data;
                else if (cfg_index == REG_OUTPUT_RATE)
                    out_rate = cfg_data;
                phase_inc = step_for(in_rate, out_rate);
            end

            mismatch_count <= errs;
            frames_due     <= expected_frames.size();
        end
    end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the resampler; checking lives in lipr_checker.
module testbench
    import lipr_pkg::*;
();

    // indexes with no register behind them
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_3 = 2'd3;

    localparam int RANDOM_FRAMES = 200;
    // settle time covers the longest item and the step divider
    localparam int SETTLE_CYCLES = 80;

    typedef enum int {IDLE_NONE, IDLE_UNIFORM, IDLE_BURSTY} idle_mode_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    rate_t                  cfg_data  = '0;
    logic                   in_valid  = 1'b0;
    sample_t                left_in   = '0;
    sample_t                right_in  = '0;
    logic                   block_end = 1'b0;
    logic                   out_stall = 1'b0;

    logic    in_stall;
    logic    out_valid;
    sample_t left_out;
    sample_t right_out;
    logic    run_last;

    int mismatch_count;
    int frames_due;

    idle_mode_t src_mode  = IDLE_UNIFORM;
    idle_mode_t sink_mode = IDLE_UNIFORM;
    int         sink_hold = 0;
    int         random_sent = 0;

    linear_interp_pcm_resampler_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .left_in   (left_in),
        .right_in  (right_in),
        .block_end (block_end),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .left_out  (left_out),
        .right_out (right_out),
        .run_last  (run_last)
    );

    lipr_checker frame_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .left_in        (left_in),
        .right_in       (right_in),
        .block_end      (block_end),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .left_out       (left_out),
        .right_out      (right_out),
        .run_last       (run_last),
        .mismatch_count (mismatch_count),
        .frames_due     (frames_due)
    );

    always #6 clk = ~clk;

    // hard stop
    initial
    begin
        #10_000_000;
        $display("FAIL linear_interp_pcm_resampler_top");
        $finish;
    end

    function automatic int idle_cycles(idle_mode_t m);
        case (m)
            IDLE_NONE:    return 0;
            IDLE_UNIFORM: return $urandom_range(12, 0);
            default:      return ($urandom_range(5, 0) == 0) ? 12 : $urandom_range(1, 0);
        endcase
    endfunction

    function automatic idle_mode_t pick_idle();
        return idle_mode_t'($urandom_range(2, 0));
    endfunction

    function automatic sample_t rand_sample();
        case ($urandom_range(7, 0))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            default: return sample_t'($urandom);
        endcase
    endfunction

    function automatic rate_t common_rate();
        case ($urandom_range(8, 0))
            0:       return 17'd8000;
            1:       return 17'd11025;
            2:       return 17'd16000;
            3:       return 17'd22050;
            4:       return 17'd32000;
            5:       return 17'd44100;
            6:       return 17'd48000;
            7:       return 17'd88200;
            default: return 17'd96000;
        endcase
    endfunction

    function automatic rate_t extreme_rate();
        case ($urandom_range(4, 0))
            0:       return '0;
            1:       return 17'd8000;
            2:       return 17'd96000;
            3:       return '1;
            default: return rate_t'($urandom);
        endcase
    endfunction

    // sink: after each output transaction hold stall for a drawn count
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sink_hold = 0;
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
                sink_hold = idle_cycles(sink_mode);
            else if (sink_hold > 0)
                sink_hold = sink_hold - 1;
            out_stall <= (sink_hold > 0);
        end
    end

    // one input transaction, then the drawn gap
    task automatic send_frame(input sample_t l, input sample_t r, input logic e);
        int gap;
        in_valid  <= 1'b1;
        left_in   <= l;
        right_in  <= r;
        block_end <= e;
        do @(posedge clk); while (in_stall);
        gap = idle_cycles(src_mode);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // stop sending and wait until every predicted frame is out
    task automatic wait_results_done();
        in_valid <= 1'b0;
        @(posedge clk);
        while (frames_due != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // single write; then let the step divider finish
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input rate_t val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin : stimulus
        int     b;
        int     k;
        int     nblocks;
        int     len;
        logic   open_end;
        logic   noisy;
        logic   e;
        rate_t  r;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // equal rates after reset: pass-through, field extremes
        send_frame(16'sh7FFF, 16'sh8000, 1'b0);
        send_frame(16'sh8000, 16'sh7FFF, 1'b1);
        send_frame(16'sh0000, 16'sh0000, 1'b0);
        send_frame(16'shFFFF, 16'sh0001, 1'b0);

        // mild upsampling; first frame of the block gives nothing
        wait_results_done();
        write_reg(REG_INPUT_RATE, 17'd44100);
        send_frame(16'sh7FFF, 16'sh8000, 1'b0);
        send_frame(16'sh8000, 16'sh7FFF, 1'b0);
        send_frame(16'sh0000, 16'shFFFF, 1'b0);
        send_frame(16'sh7FFF, 16'sh7FFF, 1'b1);
        // one-frame block
        send_frame(16'shFFFF, 16'sh0000, 1'b1);

        // heavy downsampling
        wait_results_done();
        write_reg(REG_INPUT_RATE, 17'd96000);
        write_reg(REG_OUTPUT_RATE, 17'd8000);
        send_frame(16'sh1234, 16'sh8000, 1'b0);
        send_frame(16'sh8000, 16'sh4321, 1'b0);
        send_frame(16'sh7FFF, 16'sh0000, 1'b1);

        // upsampling past the run cap
        wait_results_done();
        write_reg(REG_INPUT_RATE, 17'd8000);
        write_reg(REG_OUTPUT_RATE, 17'h1FFFF);
        send_frame(16'sh8000, 16'sh7FFF, 1'b0);
        send_frame(16'sh7FFF, 16'sh8000, 1'b0);
        send_frame(16'sh0100, 16'shFF00, 1'b1);

        // zero input rate: every run ends at the cap
        wait_results_done();
        write_reg(REG_INPUT_RATE, 17'd0);
        send_frame(16'sh7FFF, 16'sh8000, 1'b0);
        send_frame(16'sh8000, 16'sh7FFF, 1'b1);

        // zero output rate: step saturates
        wait_results_done();
        write_reg(REG_INPUT_RATE, 17'd48000);
        write_reg(REG_OUTPUT_RATE, 17'd0);
        send_frame(16'sh7FFF, 16'sh7FFF, 1'b0);
        send_frame(16'sh8000, 16'sh8000, 1'b1);

        // unused indexes are ignored; then saturated step, block left open
        wait_results_done();
        write_reg(REG_SPARE_2, 17'h1FFFF);
        write_reg(REG_SPARE_3, 17'd0);
        write_reg(REG_INPUT_RATE, 17'h1FFFF);
        write_reg(REG_OUTPUT_RATE, 17'd8000);
        send_frame(16'sh4000, 16'shC000, 1'b0);
        send_frame(16'shC000, 16'sh4000, 1'b0);

        // rate change in the middle of the open block
        wait_results_done();
        write_reg(REG_INPUT_RATE, 17'd32000);
        write_reg(REG_OUTPUT_RATE, 17'd48000);
        send_frame(16'sh0FFF, 16'shF000, 1'b0);
        send_frame(16'shF000, 16'sh0FFF, 1'b1);

        // random phases: new rates, idle pattern, a few blocks each
        while (random_sent < RANDOM_FRAMES)
        begin
            wait_results_done();
            case ($urandom_range(5, 0))
                0:
                begin
                    r = common_rate();
                    write_reg(REG_INPUT_RATE, r);
                    write_reg(REG_OUTPUT_RATE, r);
                end
                1: write_reg(REG_INPUT_RATE, common_rate());
                2: write_reg(REG_OUTPUT_RATE, common_rate());
                3:
                begin
                    write_reg(REG_INPUT_RATE, extreme_rate());
                    write_reg(REG_OUTPUT_RATE, extreme_rate());
                end
                default:
                begin
                    write_reg(REG_INPUT_RATE, common_rate());
                    write_reg(REG_OUTPUT_RATE, common_rate());
                end
            endcase
            if ($urandom_range(7, 0) == 0)
                write_reg($urandom_range(1, 0) ? REG_SPARE_2 : REG_SPARE_3, rate_t'($urandom));

            src_mode  = pick_idle();
            sink_mode = pick_idle();
            noisy     = ($urandom_range(4, 0) == 0);
            nblocks   = $urandom_range(4, 1);
            for (b = 0; b < nblocks; b++)
            begin
                len = ($urandom_range(7, 0) == 0) ? $urandom_range(24, 8) : $urandom_range(5, 1);
                open_end = (b == nblocks - 1) && ($urandom_range(2, 0) == 0);
                for (k = 0; k < len; k++)
                begin
                    // hold off once mid-run until the output side is empty
                    if (random_sent == RANDOM_FRAMES / 2)
                        wait_results_done();
                    if (noisy)
                        e = ($urandom_range(3, 0) == 0);
                    else
                        e = (k == len - 1) && !open_end;
                    send_frame(rand_sample(), rand_sample(), e);
                    random_sent++;
                end
            end
        end

        wait_results_done();
        if (mismatch_count == 0 && frames_due == 0)
            $display("PASS linear_interp_pcm_resampler_top");
        else
            $display("FAIL linear_interp_pcm_resampler_top");
        $finish;
    end

endmodule

FILE: linear_interp_pcm_resampler_top.f
+incdir+src
src/lipr_pkg.sv
src/linear_interp_pcm_resampler_top.sv
src/lipr_checker.sv
test/lipr_checker.sv
test/testbench.sv
